// ===== rtl/uokl_pkg.sv =====
package uokl_pkg;

    localparam int DEPTH = 16;
    localparam int KEY_W = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OP_W  = 3;
    localparam int POS_W = 8;
    localparam int ST_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_DEL_KEY = 3'd1,
        OP_DEL_POS = 3'd2,
        OP_GET     = 3'd3,
        OP_FIND    = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2,
        ST_DUP  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_MATCH = 2'd1,
        S_APPLY = 2'd2
    } state_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic capture;  // latch compare result
        logic live;     // cell holds a stored entry
        logic load;     // take the appended key
        logic shift;    // take the upper neighbor's key
    } cell_ctl_t;

endpackage

// ===== rtl/uokl_cell.sv =====
module uokl_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  uokl_pkg::cell_ctl_t     ctl,
    input  logic [uokl_pkg::KEY_W-1:0] cmp_key,
    input  logic [uokl_pkg::KEY_W-1:0] upper_key,
    output logic [uokl_pkg::KEY_W-1:0] cell_key,
    output logic                    hit
);
    import uokl_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             hit_reg;
    logic             hit_next;

    always_comb
    begin
        key_next = key_reg;
        if (ctl.load)
        begin
            key_next = cmp_key;
        end
        else if (ctl.shift)
        begin
            key_next = upper_key;
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.capture)
        begin
            hit_next = ctl.live && (key_reg == cmp_key);
        end
    end

    // stored key has no reset, validity comes from the count
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign cell_key = key_reg;
    assign hit      = hit_reg;

endmodule

// ===== rtl/unique_ordered_key_list_unit.sv =====
// unique ordered key list
// keeps up to DEPTH distinct keys in the order they were added, one key
// per cell in a row of cells; deletes close the gap by shifting every
// later cell down by one from its upper neighbor
// input channel: in_valid / in_stall carrying opcode, key and position;
//   a word is taken at a rising edge with in_valid high and in_stall low
// output channel: out_valid / out_stall carrying status, found_index,
//   item_value and entry_count, one result word per input word
// timing: each item passes through the accept, a compare cycle in which every cell
//   compares its key and registers a hit, and an apply cycle that picks the
//   first hit, shifts or loads the cells and writes the result register;
//   out_valid is registered at the apply
// the result sits in its own register, so the next word is taken while a
//   finished result still waits for the receiver
// when the receiver stalls with a result pending, the apply cycle of the
//   next item waits, and in_stall stays high until it completes
// reset clears the count, the sequencer and out_valid; stored keys are
//   not cleared, entries at or above the count are never read
module unique_ordered_key_list_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [uokl_pkg::OP_W-1:0]   opcode,
    input  logic [uokl_pkg::KEY_W-1:0]  key,
    input  logic [uokl_pkg::POS_W-1:0]  position,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [uokl_pkg::ST_W-1:0]   status,
    output logic [uokl_pkg::IDX_W-1:0]  found_index,
    output logic [uokl_pkg::KEY_W-1:0]  item_value,
    output logic [uokl_pkg::CNT_W-1:0]  entry_count
);
    import uokl_pkg::*;

    // sequencer
    state_t state_reg;
    state_t state_next;

    // latched input word
    logic [OP_W-1:0]  op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [POS_W-1:0] pos_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [ST_W-1:0]  status_reg;
    logic [IDX_W-1:0] found_index_reg;
    logic [KEY_W-1:0] item_value_reg;
    logic [CNT_W-1:0] entry_count_reg;

    // cell row
    cell_ctl_t        cell_ctl [DEPTH];
    logic [KEY_W-1:0] cell_key [DEPTH];
    logic [DEPTH-1:0] hit_vec;
    logic [DEPTH-1:0] first_oh;
    logic [DEPTH-1:0] load_vec;
    logic [DEPTH-1:0] shift_vec;
    logic [DEPTH-1:0] live_vec;

    logic             in_fire;
    logic             apply_fire;
    logic             hit_any;
    logic             pos_ok;
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] drop_idx;
    logic             do_add;
    logic             do_drop;
    logic [ST_W-1:0]  res_status;
    logic [IDX_W-1:0] res_index;
    logic [KEY_W-1:0] res_value;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign apply_fire = (state_reg == S_APPLY) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= opcode;
            key_reg <= key;
            pos_reg <= position;
        end
    end

    // first hit: isolate the lowest set bit, then encode
    assign hit_any  = |hit_vec;
    assign first_oh = hit_vec & (~hit_vec + 1'b1);

    always_comb
    begin
        first_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first_oh[i])
            begin
                first_idx = first_idx | IDX_W'(i);
            end
        end
    end

    assign pos_ok = (pos_reg < POS_W'(count_reg));

    // decide the operation
    always_comb
    begin
        do_add     = 1'b0;
        do_drop    = 1'b0;
        drop_idx   = first_idx;
        res_status = ST_MISS;
        res_index  = '0;
        res_value  = '0;
        case (op_reg)
            OP_ADD:
            begin
                if (hit_any)
                begin
                    res_status = ST_DUP;
                end
                else if (count_reg == CNT_W'(DEPTH))
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    do_add     = 1'b1;
                    res_status = ST_DONE;
                end
            end
            OP_DEL_KEY:
            begin
                if (hit_any)
                begin
                    do_drop    = 1'b1;
                    res_status = ST_DONE;
                end
            end
            OP_DEL_POS:
            begin
                drop_idx = pos_reg[IDX_W-1:0];
                if (pos_ok)
                begin
                    do_drop    = 1'b1;
                    res_status = ST_DONE;
                end
            end
            OP_GET:
            begin
                if (pos_ok)
                begin
                    res_value  = cell_key[pos_reg[IDX_W-1:0]];
                    res_status = ST_DONE;
                end
            end
            OP_FIND:
            begin
                if (hit_any)
                begin
                    res_index  = first_idx;
                    res_status = ST_DONE;
                end
            end
            default:
            begin
                res_status = ST_MISS;
            end
        endcase
    end

    // per-cell enables
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            live_vec[i]  = (CNT_W'(i) < count_reg);
            load_vec[i]  = apply_fire && do_add && (count_reg == CNT_W'(i));
            shift_vec[i] = apply_fire && do_drop && (IDX_W'(i) >= drop_idx)
                           && (CNT_W'(i + 1) < count_reg);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (apply_fire && do_add)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (apply_fire && do_drop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [KEY_W-1:0] upper;
            if (g == DEPTH - 1)
            begin : g_top
                assign upper = '0;
            end
            else
            begin : g_mid
                assign upper = cell_key[g+1];
            end

            assign cell_ctl[g].capture = (state_reg == S_MATCH);
            assign cell_ctl[g].live    = live_vec[g];
            assign cell_ctl[g].load    = load_vec[g];
            assign cell_ctl[g].shift   = shift_vec[g];

            uokl_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (cell_ctl[g]),
                .cmp_key   (key_reg),
                .upper_key (upper),
                .cell_key  (cell_key[g]),
                .hit       (hit_vec[g])
            );
        end
    endgenerate

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (apply_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply_fire)
        begin
            status_reg      <= res_status;
            found_index_reg <= res_index;
            item_value_reg  <= res_value;
            entry_count_reg <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_index = found_index_reg;
    assign item_value  = item_value_reg;
    assign entry_count = entry_count_reg;

    // count never exceeds the row length
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count beyond depth");

    // one operation moves the count by at most one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg))
              || (count_reg == $past(count_reg) + 1'b1)
              || (count_reg == $past(count_reg) - 1'b1))
        else $error("count jumped");

    // compare cycle always follows an accepted word
    a_match_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_MATCH))
        else $error("no compare cycle after accept");

    // at most one cell takes an appended key
    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(load_vec))
        else $error("several cells loaded");

    // a result appears right after each apply
    a_result_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        apply_fire |=> out_valid_reg)
        else $error("result lost");

endmodule

// ===== sim/key_list_checker.sv =====
module key_list_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [uokl_pkg::OP_W-1:0]   opcode,
    input  logic [uokl_pkg::KEY_W-1:0]  key,
    input  logic [uokl_pkg::POS_W-1:0]  position,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [uokl_pkg::ST_W-1:0]   status,
    input  logic [uokl_pkg::IDX_W-1:0]  found_index,
    input  logic [uokl_pkg::KEY_W-1:0]  item_value,
    input  logic [uokl_pkg::CNT_W-1:0]  entry_count,
    output int                          error_count,
    output int                          pending,
    output int                          words_checked,
    output int                          full_drops,
    output int                          dup_hits,
    output int                          miss_hits
);

    timeunit 1ns;
    timeprecision 1ps;

    import uokl_pkg::*;

    typedef struct packed {
        status_t          st;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] val;
        logic [CNT_W-1:0] cnt;
    } list_result_t;

    // shadow copy of the key row and its fill level
    logic [KEY_W-1:0] shadow_keys [DEPTH];
    int               shadow_len;
    list_result_t     expected_results [$];
    list_result_t     want;

    function automatic void drop_entry(int at);
        for (int j = at; j < shadow_len - 1; j++)
            shadow_keys[j] = shadow_keys[j + 1];
        shadow_len--;
    endfunction

    function automatic list_result_t apply_list_op(logic [OP_W-1:0] op,
                                                   logic [KEY_W-1:0] k,
                                                   logic [POS_W-1:0] p);
        list_result_t r;
        int           hit;
        r.st  = ST_MISS;
        r.idx = '0;
        r.val = '0;
        hit   = -1;
        for (int i = 0; i < shadow_len; i++)
            if (hit < 0 && shadow_keys[i] == k)
                hit = i;
        case (op)
            OP_ADD:
            begin
                if (hit >= 0)
                    r.st = ST_DUP;
                else if (shadow_len >= DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    shadow_keys[shadow_len] = k;
                    shadow_len++;
                    r.st = ST_DONE;
                end
            end
            OP_DEL_KEY:
            begin
                if (hit >= 0)
                begin
                    drop_entry(hit);
                    r.st = ST_DONE;
                end
            end
            OP_DEL_POS:
            begin
                if (int'(p) < shadow_len)
                begin
                    drop_entry(int'(p));
                    r.st = ST_DONE;
                end
            end
            OP_GET:
            begin
                if (int'(p) < shadow_len)
                begin
                    r.val = shadow_keys[p];
                    r.st  = ST_DONE;
                end
            end
            OP_FIND:
            begin
                if (hit >= 0)
                begin
                    r.idx = IDX_W'(hit);
                    r.st  = ST_DONE;
                end
            end
            default: ;
        endcase
        r.cnt = CNT_W'(shadow_len);
        return r;
    endfunction

    function automatic void compare_field(string fname, logic [KEY_W-1:0] exp_v,
                                          logic [KEY_W-1:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s expected %0h got %0h", $time, fname, exp_v, got_v);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_len    = 0;
            expected_results.delete();
            error_count   = 0;
            pending       = 0;
            words_checked = 0;
            full_drops    = 0;
            dup_hits      = 0;
            miss_hits     = 0;
        end
        else
        begin
            // results are checked before this edge's word is predicted
            if (out_valid && !out_stall)
            begin
                words_checked++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, status %0d count %0d",
                             $time, status, entry_count);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("status", want.st, status);
                    compare_field("found_index", want.idx, found_index);
                    compare_field("item_value", want.val, item_value);
                    compare_field("entry_count", want.cnt, entry_count);
                    if (want.st == ST_FULL)
                        full_drops++;
                    if (want.st == ST_DUP)
                        dup_hits++;
                    if (want.st == ST_MISS)
                        miss_hits++;
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(apply_list_op(opcode, key, position));
            pending = expected_results.size();
        end
    end

endmodule

// ===== sim/unique_ordered_key_list_unit_tb.sv =====
module unique_ordered_key_list_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import uokl_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 200;
    localparam int POOL_SIZE    = 24;
    localparam int LONG_HOLD    = 120;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 10;

    // phase flavors: grow fills the list, shrink empties it
    localparam int PH_GROW   = 0;
    localparam int PH_SHRINK = 1;
    localparam int PH_MIXED  = 2;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [OP_W-1:0]  opcode = '0;
    logic [KEY_W-1:0] key = '0;
    logic [POS_W-1:0] position = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] found_index;
    logic [KEY_W-1:0] item_value;
    logic [CNT_W-1:0] entry_count;

    int error_count;
    int pending;
    int words_checked;
    int full_drops;
    int dup_hits;
    int miss_hits;

    int   words_sent = 0;
    int   idle_cycles = 0;
    logic long_hold_req = 1'b0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    // free-running clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    unique_ordered_key_list_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .key         (key),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_index (found_index),
        .item_value  (item_value),
        .entry_count (entry_count)
    );

    key_list_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .key           (key),
        .position      (position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found_index   (found_index),
        .item_value    (item_value),
        .entry_count   (entry_count),
        .error_count   (error_count),
        .pending       (pending),
        .words_checked (words_checked),
        .full_drops    (full_drops),
        .dup_hits      (dup_hits),
        .miss_hits     (miss_hits)
    );

    // offer one word from a falling edge and hold it until taken;
    // valid stays high on return so a burst runs back to back
    task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic [POS_W-1:0] p);
        in_valid <= 1'b1;
        opcode   <= op;
        key      <= k;
        position <= p;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic idle_for(input int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // stop offering until every outstanding result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // one random word, op mix skewed by the phase flavor; keys mostly come
    // from a small pool so duplicates, hits and a full list are common
    task automatic send_random(input int flavor);
        int               r;
        int               t_add;
        int               t_dkey;
        int               t_dpos;
        int               t_get;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] k;
        logic [POS_W-1:0] p;
        case (flavor)
            PH_GROW:
            begin
                t_add = 55; t_dkey = 63; t_dpos = 68; t_get = 82;
            end
            PH_SHRINK:
            begin
                t_add = 15; t_dkey = 45; t_dpos = 70; t_get = 82;
            end
            default:
            begin
                t_add = 30; t_dkey = 45; t_dpos = 55; t_get = 75;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < t_add)
            op = OP_ADD;
        else if (r < t_dkey)
            op = OP_DEL_KEY;
        else if (r < t_dpos)
            op = OP_DEL_POS;
        else if (r < t_get)
            op = OP_GET;
        else if (r < 96)
            op = OP_FIND;
        else
            op = OP_W'($urandom_range(int'(OP_FIND) + 1, 2**OP_W - 1));

        // full-width random keys now and then so every key bit toggles
        if ($urandom_range(0, 99) < 85)
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            k = $urandom;

        r = $urandom_range(0, 99);
        if (r < 70)
            p = POS_W'($urandom_range(0, DEPTH + 1));
        else if (r < 90)
            p = POS_W'($urandom_range(0, DEPTH - 1));
        else
            p = POS_W'($urandom_range(0, 2**POS_W - 1));
        send_word(op, k, p);
    endtask

    // stimulus: directed corner words, then phases of bursty random traffic
    initial
    begin
        int n;
        int burst;

        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h0000_0001;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // reset held low from the start, released on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list: every lookup and delete misses
        send_word(OP_FIND, 32'h0, 8'd0);
        send_word(OP_GET, 32'h0, 8'd0);
        send_word(OP_DEL_POS, 32'h0, 8'd0);
        send_word(OP_DEL_KEY, 32'h0, 8'd0);
        // extreme keys, then a duplicate add
        send_word(OP_ADD, 32'h0, 8'd0);
        send_word(OP_ADD, 32'hFFFF_FFFF, 8'hFF);
        send_word(OP_ADD, 32'h0, 8'd0);
        send_word(OP_ADD, 32'h8000_0000, 8'd0);
        // gets in range, at the count, and at the top position
        send_word(OP_GET, 32'h0, 8'd0);
        send_word(OP_GET, 32'h0, 8'd2);
        send_word(OP_GET, 32'h0, 8'd3);
        send_word(OP_GET, 32'hFFFF_FFFF, 8'hFF);
        // find hit and miss
        send_word(OP_FIND, 32'hFFFF_FFFF, 8'd0);
        send_word(OP_FIND, 32'h1234_5678, 8'd0);
        // delete the head by key so the rest compacts, then read it back
        send_word(OP_DEL_KEY, 32'h0, 8'd0);
        send_word(OP_GET, 32'h0, 8'd0);
        send_word(OP_DEL_POS, 32'h0, 8'd1);
        send_word(OP_DEL_POS, 32'h0, 8'd200);
        // undefined opcodes do nothing and report a miss
        for (int u = int'(OP_FIND) + 1; u < 2**OP_W; u++)
            send_word(OP_W'(u), 32'hFFFF_FFFF, 8'hFF);
        send_word(OP_DEL_KEY, 32'hFFFF_FFFF, 8'd0);
        send_word(OP_FIND, 32'hFFFF_FFFF, 8'd0);
        drain_results();

        // receiver goes quiet for a long stretch while bursts keep coming
        long_hold_req = 1'b1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            n = 0;
            while (n < PHASE_WORDS)
            begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < PHASE_WORDS; b++)
                begin
                    send_random(ph % 3);
                    n++;
                end
                // some bursts run straight into the next one
                if ($urandom_range(0, 3) != 0)
                    idle_for($urandom_range(1, 8));
            end
            // sender waits for the pipe to empty at every phase boundary
            drain_results();
        end

        repeat (SETTLE) @(negedge clk);
        $display("summary: %0d words in grow, shrink and mixed phases, %0d results checked",
                 words_sent, words_checked);
        $display("summary: %0d adds refused on a full list, %0d duplicate adds, %0d misses",
                 full_drops, dup_hits, miss_hits);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver stall pattern: free-flowing, light, heavy and solid stretches,
    // plus one long hold-off once the random traffic starts
    initial
    begin
        int   seg_len;
        int   kind;
        int   pct;
        logic long_hold_done;

        long_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (long_hold_req && !long_hold_done)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                kind    = $urandom_range(0, 3);
                seg_len = $urandom_range(4, 40);
                case (kind)
                    0: pct = 0;
                    1: pct = 50;
                    2: pct = 80;
                    default:
                    begin
                        pct     = 100;
                        seg_len = $urandom_range(1, 6);
                    end
                endcase
                repeat (seg_len)
                begin
                    out_stall <= ($urandom_range(1, 100) <= pct);
                    @(negedge clk);
                end
            end
        end
    end

    // watchdog: too many cycles without a word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                         idle_cycles, pending);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule
